// ----- design/psbp_pkg.sv -----
package psbp_pkg;

  // Field widths
  localparam int SPEED_W = 16;
  localparam int ERR_W   = SPEED_W + 1;
  localparam int DIFF_W  = ERR_W + 1;
  localparam int SUM_W   = 32;
  localparam int GAIN_W  = 16;
  localparam int DRIVE_W = 11;
  localparam int DUTY_W  = 10;
  localparam int ACC_W   = 50;

  // Output clamp limit
  localparam logic signed [DRIVE_W-1:0] DUTY_MAX = 11'sd1023;

  // Register reset values, unsigned Q8.8
  localparam logic [GAIN_W-1:0] GAIN_P_RESET = 16'd1408;
  localparam logic [GAIN_W-1:0] GAIN_I_RESET = 16'd307;
  localparam logic [GAIN_W-1:0] GAIN_D_RESET = 16'd13;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_GAIN_P = 2'd0,
    REG_GAIN_I = 2'd1,
    REG_GAIN_D = 2'd2
  } cfg_reg_t;

  // Item mode flag
  localparam logic MODE_STEP    = 1'b0;
  localparam logic MODE_RESTART = 1'b1;

  typedef struct packed {
    logic [GAIN_W-1:0] gain_p;
    logic [GAIN_W-1:0] gain_i;
    logic [GAIN_W-1:0] gain_d;
  } gains_t;

  typedef struct packed {
    logic [DUTY_W-1:0]         reverse_duty;
    logic [DUTY_W-1:0]         forward_duty;
    logic signed [DRIVE_W-1:0] drive;
  } pid_result_t;

endpackage

// ----- design/pid_speed_to_bidir_pwm_core.sv -----
// PID speed controller with clamped output split into forward/reverse PWM duty.
// Path: input register, single-pass PID math, result register.
// Throughput: one item per cycle unless m_axis_tready stalls the result.
// Reset (rst, synchronous): gains to defaults, integral and previous error cleared,
// both pipeline registers empty.
module pid_speed_to_bidir_pwm_core (
  input  logic        clk,
  input  logic        rst,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] target_speed, [31:16] measured_speed
  input  logic [0:0]  s_axis_tuser,   // [0] mode
  // Result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [10:0] drive, [20:11] forward_duty,
                                      // [30:21] reverse_duty, [31] zero
  // Configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  psbp_pkg::gains_t      gains;
  psbp_pkg::pid_result_t calc_res;
  psbp_pkg::pid_result_t out_res;

  logic                                in_valid;
  logic                                in_mode;
  logic signed [psbp_pkg::SPEED_W-1:0] in_target;
  logic signed [psbp_pkg::SPEED_W-1:0] in_measured;
  logic                                out_valid;
  logic                                advance;
  logic                                in_fire;

  // Handshake
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  psbp_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .gains     (gains)
  );

  psbp_pid_calc u_calc (
    .clk            (clk),
    .rst            (rst),
    .step_en        (advance),
    .mode           (in_mode),
    .target_speed   (in_target),
    .measured_speed (in_measured),
    .gains          (gains),
    .result         (calc_res)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_fire) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_mode     <= s_axis_tuser[0];
      in_target   <= s_axis_tdata[15:0];
      in_measured <= s_axis_tdata[31:16];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= calc_res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0, out_res.reverse_duty, out_res.forward_duty, out_res.drive};

`ifndef ASSERT_OFF
  a_drive_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_res.drive != {1'b1, {(psbp_pkg::DRIVE_W-1){1'b0}}})
    else $error("drive outside clamp range");

  a_duty_split: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_res.forward_duty == '0 || out_res.reverse_duty == '0))
    else $error("forward and reverse duty both active");

  a_restart_zero: assert property (@(posedge clk) disable iff (rst)
    advance && in_mode == psbp_pkg::MODE_RESTART |=> out_valid && out_res.drive == '0)
    else $error("restart item produced nonzero drive");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !m_axis_tready |-> !advance)
    else $error("stalled result overwritten");
`endif

endmodule

// ----- design/psbp_cfg_regs.sv -----
module psbp_cfg_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [1:0]                   cfg_index,
  input  logic [psbp_pkg::GAIN_W-1:0]  cfg_data,
  output psbp_pkg::gains_t             gains
);

  psbp_pkg::gains_t gains_next;

  // Writes are taken every cycle
  assign cfg_ready = 1'b1;

  // Index decode; unknown indexes leave the gains alone
  always_comb begin
    gains_next = gains;
    if (cfg_valid) begin
      unique case (cfg_index)
        psbp_pkg::REG_GAIN_P: gains_next.gain_p = cfg_data;
        psbp_pkg::REG_GAIN_I: gains_next.gain_i = cfg_data;
        psbp_pkg::REG_GAIN_D: gains_next.gain_d = cfg_data;
        default:              gains_next = gains;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gains.gain_p <= psbp_pkg::GAIN_P_RESET;
      gains.gain_i <= psbp_pkg::GAIN_I_RESET;
      gains.gain_d <= psbp_pkg::GAIN_D_RESET;
    end else begin
      gains <= gains_next;
    end
  end

endmodule

// ----- design/psbp_pid_calc.sv -----
module psbp_pid_calc (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                step_en,
  input  logic                                mode,
  input  logic signed [psbp_pkg::SPEED_W-1:0] target_speed,
  input  logic signed [psbp_pkg::SPEED_W-1:0] measured_speed,
  input  psbp_pkg::gains_t                    gains,
  output psbp_pkg::pid_result_t               result
);

  logic signed [psbp_pkg::SUM_W-1:0]    error_sum;
  logic signed [psbp_pkg::SUM_W-1:0]    error_sum_next;
  logic signed [psbp_pkg::ERR_W-1:0]    last_error;
  logic signed [psbp_pkg::ERR_W-1:0]    last_error_next;

  logic signed [psbp_pkg::ERR_W-1:0]    err;
  logic signed [psbp_pkg::SUM_W:0]      acc;
  logic signed [psbp_pkg::SUM_W-1:0]    acc_sat;
  logic signed [psbp_pkg::DIFF_W-1:0]   diff;
  logic signed [psbp_pkg::GAIN_W:0]     kp;
  logic signed [psbp_pkg::GAIN_W:0]     ki;
  logic signed [psbp_pkg::GAIN_W:0]     kd;
  logic signed [psbp_pkg::GAIN_W+psbp_pkg::ERR_W:0]  prod_p;
  logic signed [psbp_pkg::GAIN_W+psbp_pkg::SUM_W:0]  prod_i;
  logic signed [psbp_pkg::GAIN_W+psbp_pkg::DIFF_W:0] prod_d;
  logic signed [psbp_pkg::ACC_W-1:0]    total;
  logic signed [psbp_pkg::ACC_W-1:0]    total_adj;
  logic signed [psbp_pkg::ACC_W-1:0]    quot;
  logic signed [psbp_pkg::DRIVE_W-1:0]  drive;
  logic signed [psbp_pkg::DRIVE_W-1:0]  drive_neg;

  // Error, saturating integral, derivative
  always_comb begin
    err  = psbp_pkg::ERR_W'(target_speed) - psbp_pkg::ERR_W'(measured_speed);
    acc  = (psbp_pkg::SUM_W+1)'(error_sum) + (psbp_pkg::SUM_W+1)'(err);
    if (acc[psbp_pkg::SUM_W] != acc[psbp_pkg::SUM_W-1]) begin
      acc_sat = acc[psbp_pkg::SUM_W] ? {1'b1, {(psbp_pkg::SUM_W-1){1'b0}}}
                                     : {1'b0, {(psbp_pkg::SUM_W-1){1'b1}}};
    end else begin
      acc_sat = acc[psbp_pkg::SUM_W-1:0];
    end
    diff = psbp_pkg::DIFF_W'(err) - psbp_pkg::DIFF_W'(last_error);
  end

  // Gain products, gains zero-extended into signed operands
  always_comb begin
    kp     = $signed({1'b0, gains.gain_p});
    ki     = $signed({1'b0, gains.gain_i});
    kd     = $signed({1'b0, gains.gain_d});
    prod_p = kp * err;
    prod_i = ki * acc_sat;
    prod_d = kd * diff;
  end

  // Sum, divide by 256 toward zero, clamp; restart items force zero drive
  always_comb begin
    total     = psbp_pkg::ACC_W'(prod_p) + psbp_pkg::ACC_W'(prod_i)
              + psbp_pkg::ACC_W'(prod_d);
    total_adj = total[psbp_pkg::ACC_W-1] ? total + psbp_pkg::ACC_W'(255) : total;
    quot      = total_adj >>> 8;
    if (quot > psbp_pkg::ACC_W'(psbp_pkg::DUTY_MAX)) begin
      drive = psbp_pkg::DUTY_MAX;
    end else if (quot < -psbp_pkg::ACC_W'(psbp_pkg::DUTY_MAX)) begin
      drive = -psbp_pkg::DUTY_MAX;
    end else begin
      drive = quot[psbp_pkg::DRIVE_W-1:0];
    end
    if (mode == psbp_pkg::MODE_RESTART) begin
      drive = '0;
    end
  end

  // Split by sign into forward and reverse duty
  always_comb begin
    drive_neg           = -drive;
    result.drive        = drive;
    result.forward_duty = drive[psbp_pkg::DRIVE_W-1] ? '0
                                                     : drive[psbp_pkg::DUTY_W-1:0];
    result.reverse_duty = drive[psbp_pkg::DRIVE_W-1] ? drive_neg[psbp_pkg::DUTY_W-1:0]
                                                     : '0;
  end

  // Controller state update
  always_comb begin
    error_sum_next  = error_sum;
    last_error_next = last_error;
    if (step_en) begin
      if (mode == psbp_pkg::MODE_RESTART) begin
        error_sum_next  = '0;
        last_error_next = '0;
      end else begin
        error_sum_next  = acc_sat;
        last_error_next = err;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      error_sum  <= '0;
      last_error <= '0;
    end else begin
      error_sum  <= error_sum_next;
      last_error <= last_error_next;
    end
  end

`ifndef ASSERT_OFF
  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    step_en && mode == psbp_pkg::MODE_RESTART |=> error_sum == '0 && last_error == '0)
    else $error("restart did not clear controller state");
`endif

endmodule
